FILE: rtl/utlc_pkg.sv
// ----------------------------------------------------------------------------
// utlc_pkg: shared types for the universal tree leaf counter
// Memo word layout and sequencer state encoding.
// ----------------------------------------------------------------------------
package utlc_pkg;

  // one memo entry: wrapped count plus sticky overflow marker
  typedef struct packed {
    logic        big;
    logic [31:0] val;
  } memo_word_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_CALC_V,
    ST_CALC_U,
    ST_DONE
  } state_e;

endpackage

FILE: rtl/utlc_memo_ram.sv
// ----------------------------------------------------------------------------
// utlc_memo_ram: memo storage for one tree kind
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module utlc_memo_ram #(
  parameter int DEPTH = 9537,
  parameter int AW    = 14
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  utlc_pkg::memo_word_t wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output utlc_pkg::memo_word_t rdata_o
);

  utlc_pkg::memo_word_t mem [DEPTH];
  utlc_pkg::memo_word_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/universal_tree_leaf_counter_core.sv
// ----------------------------------------------------------------------------
// universal_tree_leaf_counter_core: leaf count of the U tree for (k, t, h)
// Fills U and V memos bottom-up and returns U(k,t,h) with overflow flags.
// ----------------------------------------------------------------------------
// Steps: a point of the k=1 row is written in ST_ISSUE, a point with t'=0 passes
//   ST_ISSUE and ST_CALC_V, every other point ST_ISSUE, ST_CALC_V and ST_CALC_U,
//   over all k'<=k, t'<=t, k'<=h'<=h. A rejected query goes straight to ST_DONE.
// Throughput: one query at a time; a new query is accepted only in ST_IDLE.
// Reset: sequencer state and output valid cleared; the memos are not cleared, since
//   every entry a query reads was written earlier in the same query.
// ----------------------------------------------------------------------------
module universal_tree_leaf_counter_core #(
  parameter int MAX_K = 16,
  parameter int MAX_T = 16,
  parameter int MAX_H = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // depth_k[4:0], width_t[9:5], height_h[15:10]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // leaf_count[31:0]
  output logic [1:0]  m_axis_tuser_o    // overflowed[0], bad_query[1]
);

  localparam int DIM_K = MAX_K + 1;
  localparam int DIM_T = MAX_T + 1;
  localparam int DIM_H = MAX_H + 1;
  localparam int DEPTH = DIM_K * DIM_T * DIM_H;
  localparam int AW    = $clog2(DEPTH);

  // memo index of point (k, t, h)
  function automatic logic [AW-1:0] memo_addr(logic [4:0] k, logic [4:0] t, logic [5:0] h);
    logic [AW-1:0] kt;
    kt = AW'(k) * AW'(DIM_T) + AW'(t);
    return kt * AW'(DIM_H) + AW'(h);
  endfunction

  // 2*a + b with sticky overflow
  function automatic utlc_pkg::memo_word_t dbl_add(utlc_pkg::memo_word_t a,
                                                   utlc_pkg::memo_word_t b);
    logic [33:0]          s;
    utlc_pkg::memo_word_t r;
    s     = {1'b0, a.val, 1'b0} + {2'b00, b.val};
    r.val = s[31:0];
    r.big = a.big | b.big | (s[33:32] != 2'b00);
    return r;
  endfunction

  utlc_pkg::state_e state_q, state_d;
  logic [4:0] k_q, k_d, t_q, t_d, kk_q, kk_d, tt_q, tt_d;
  logic [5:0] h_q, h_d, hh_q, hh_d;
  logic       bad_q, bad_d;
  utlc_pkg::memo_word_t u_q, u_d, v_q, v_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_count_q, out_count_d;
  logic        out_ovf_q, out_ovf_d, out_bad_q, out_bad_d;

  logic                 u_we, u_re, v_we, v_re;
  logic [AW-1:0]        u_waddr, u_raddr, v_waddr, v_raddr;
  utlc_pkg::memo_word_t u_wdata, v_wdata, u_rdata, v_rdata;

  logic [4:0] in_k, in_t;
  logic [5:0] in_h;
  logic       in_bad, in_fire;
  logic [AW-1:0] cur_addr;
  utlc_pkg::memo_word_t v_new, u_new;

  assign in_k    = s_axis_tdata_i[4:0];
  assign in_t    = s_axis_tdata_i[9:5];
  assign in_h    = s_axis_tdata_i[15:10];
  assign in_fire = s_axis_tvalid_i & s_axis_tready_o;
  assign s_axis_tready_o = (state_q == utlc_pkg::ST_IDLE);

  // query range check
  assign in_bad = (in_k == 5'd0) || (32'(in_k) > 32'(MAX_K)) || (32'(in_t) > 32'(MAX_T))
               || (32'(in_h) > 32'(MAX_H)) || (in_h < {1'b0, in_k});

  assign cur_addr = memo_addr(kk_q, tt_q, hh_q);
  assign v_new    = dbl_add(v_rdata, u_rdata);
  assign u_new    = dbl_add(v_q, u_q);

  // memos for U and V trees
  utlc_memo_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (u_we),
    .waddr_i (u_waddr),
    .wdata_i (u_wdata),
    .re_i    (u_re),
    .raddr_i (u_raddr),
    .rdata_o (u_rdata)
  );

  utlc_memo_ram #(.DEPTH(DEPTH), .AW(AW)) v_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .re_i    (v_re),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  // sequencer: next state, loop counters and memo control
  always_comb begin
    logic advance;
    state_d     = state_q;
    k_d         = k_q;
    t_d         = t_q;
    h_d         = h_q;
    kk_d        = kk_q;
    tt_d        = tt_q;
    hh_d        = hh_q;
    bad_d       = bad_q;
    u_d         = u_q;
    v_d         = v_q;
    out_valid_d = out_valid_q;
    out_count_d = out_count_q;
    out_ovf_d   = out_ovf_q;
    out_bad_d   = out_bad_q;
    u_we        = 1'b0;
    v_we        = 1'b0;
    u_re        = 1'b0;
    v_re        = 1'b0;
    u_waddr     = cur_addr;
    v_waddr     = cur_addr;
    u_wdata     = u_q;
    v_wdata     = v_q;
    u_raddr     = memo_addr(5'(kk_q - 5'd1), tt_q, 6'(hh_q - 6'd1));
    v_raddr     = memo_addr(kk_q, 5'(tt_q - 5'd1), hh_q);
    advance     = 1'b0;

    // result transaction taken
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      utlc_pkg::ST_IDLE: begin
        if (in_fire) begin
          k_d   = in_k;
          t_d   = in_t;
          h_d   = in_h;
          kk_d  = 5'd1;
          tt_d  = 5'd0;
          hh_d  = 6'd1;
          bad_d = in_bad;
          state_d = in_bad ? utlc_pkg::ST_DONE : utlc_pkg::ST_ISSUE;
        end
      end
      utlc_pkg::ST_ISSUE: begin
        if (kk_q == 5'd1) begin
          // base row: U is one
          u_we    = 1'b1;
          u_wdata = '{big: 1'b0, val: 32'd1};
          u_d     = '{big: 1'b0, val: 32'd1};
          advance = 1'b1;
        end else begin
          u_re    = 1'b1;
          v_re    = (tt_q != 5'd0);
          state_d = utlc_pkg::ST_CALC_V;
        end
      end
      utlc_pkg::ST_CALC_V: begin
        if (tt_q == 5'd0) begin
          // zero branching: U and V copy U(k-1,0,h-1)
          u_we    = 1'b1;
          v_we    = 1'b1;
          u_wdata = u_rdata;
          v_wdata = u_rdata;
          u_d     = u_rdata;
          v_d     = u_rdata;
          advance = 1'b1;
        end else begin
          v_we    = 1'b1;
          v_wdata = v_new;
          v_d     = v_new;
          state_d = utlc_pkg::ST_CALC_U;
        end
      end
      utlc_pkg::ST_CALC_U: begin
        // u_q holds U(k,t,h-1) from the previous point
        u_we = 1'b1;
        if (hh_q == {1'b0, kk_q}) begin
          u_wdata = v_q;
          u_d     = v_q;
        end else begin
          u_wdata = u_new;
          u_d     = u_new;
        end
        advance = 1'b1;
      end
      utlc_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_count_d = bad_q ? 32'd0 : u_q.val;
          out_ovf_d   = bad_q ? 1'b0 : u_q.big;
          out_bad_d   = bad_q;
          state_d     = utlc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = utlc_pkg::ST_IDLE;
      end
    endcase

    // step to the next memo point: h, then t, then k
    if (advance) begin
      state_d = utlc_pkg::ST_ISSUE;
      if (hh_q != h_q) begin
        hh_d = 6'(hh_q + 6'd1);
      end else if (tt_q != t_q) begin
        tt_d = 5'(tt_q + 5'd1);
        hh_d = {1'b0, kk_q};
      end else if (kk_q != k_q) begin
        kk_d = 5'(kk_q + 5'd1);
        tt_d = 5'd0;
        hh_d = {1'b0, 5'(kk_q + 5'd1)};
      end else begin
        state_d = utlc_pkg::ST_DONE;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= utlc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    k_q         <= k_d;
    t_q         <= t_d;
    h_q         <= h_d;
    kk_q        <= kk_d;
    tt_q        <= tt_d;
    hh_q        <= hh_d;
    bad_q       <= bad_d;
    u_q         <= u_d;
    v_q         <= v_d;
    out_count_q <= out_count_d;
    out_ovf_q   <= out_ovf_d;
    out_bad_q   <= out_bad_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_count_q;
  assign m_axis_tuser_o  = {out_bad_q, out_ovf_q};

endmodule
